// ===== design/fir_pkg.sv =====
`default_nettype none

package fir_pkg;

	// Opcode of an input beat
	localparam logic OP_FILTER = 1'b0;
	localparam logic OP_LOAD   = 1'b1;

	// Width of the coefficient index field
	localparam int IDX_BITS = 5;

	// Per-cycle controls from the top level to each tap cell
	typedef struct packed {
		logic shift;    // take the neighbor's sample, snapshot the product
		logic coef_we;  // write this cell's coefficient
	} cell_ctl_t;

endpackage

`default_nettype wire

// ===== design/fir_in_if.sv =====
`default_nettype none

interface fir_in_if #(
	parameter int SAMPLE_BITS = 16,
	parameter int COEF_BITS   = 16
);
	logic                          valid;
	logic                          ready;
	logic                          opcode;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic [fir_pkg::IDX_BITS-1:0]  coef_index;
	logic signed [COEF_BITS-1:0]   coef_value;

	modport source (output valid, output opcode, output sample, output coef_index,
		output coef_value, input ready);
	modport sink (input valid, input opcode, input sample, input coef_index,
		input coef_value, output ready);
endinterface

`default_nettype wire

// ===== design/fir_out_if.sv =====
`default_nettype none

interface fir_out_if #(
	parameter int ACC_BITS = 40
);
	logic                       valid;
	logic                       ready;
	logic signed [ACC_BITS-1:0] filtered;

	modport source (output valid, output filtered, input ready);
	modport sink (input valid, input filtered, output ready);
endinterface

`default_nettype wire

// ===== design/fir_cell.sv =====
`default_nettype none

// One tap: holds a delay-line entry and its coefficient, and registers the
// tap product for the sample that is being shifted in.
module fir_cell #(
	parameter int SAMPLE_BITS = 16,
	parameter int COEF_BITS   = 16,
	parameter int ACC_BITS    = 40
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire fir_pkg::cell_ctl_t        ctl,
	input  wire logic signed [SAMPLE_BITS-1:0] d_in,
	input  wire logic signed [COEF_BITS-1:0]   coef_in,
	output logic signed [SAMPLE_BITS-1:0]  d_out,
	output logic [ACC_BITS-1:0]            prod
);

	localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS;
	localparam int EXT_BITS  = (PROD_BITS > ACC_BITS) ? PROD_BITS : ACC_BITS;

	logic signed [SAMPLE_BITS-1:0] tap_q;
	logic signed [COEF_BITS-1:0]   coef_q;
	logic signed [PROD_BITS-1:0]   mul;
	logic signed [EXT_BITS-1:0]    mul_ext;
	logic [ACC_BITS-1:0]           prod_s1;

	// Product of the entry this cell holds after the shift
	assign mul     = PROD_BITS'(d_in) * PROD_BITS'(coef_q);
	assign mul_ext = EXT_BITS'(mul);

	// Advance the delay line and load the coefficient
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q  <= '0;
			coef_q <= '0;
		end else begin
			if (ctl.shift) begin
				tap_q <= d_in;
			end
			if (ctl.coef_we) begin
				coef_q <= coef_in;
			end
		end
	end

	// Snapshot the wrapped product for the adder tree
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			prod_s1 <= mul_ext[ACC_BITS-1:0];
		end
	end

	assign d_out = tap_q;
	assign prod  = prod_s1;

endmodule

`default_nettype wire

// ===== design/fir_sum_tree.sv =====
`default_nettype none

// Registered binary adder tree with per-level valid bits and a ready chain,
// so a bubble at any level is filled while later levels stall.
module fir_sum_tree #(
	parameter int NUM_TAPS = 32,
	parameter int ACC_BITS = 40
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      load,
	output logic                     ready0,
	input  wire logic [ACC_BITS-1:0] prod [NUM_TAPS],
	output logic                     out_valid,
	input  wire                      out_ready,
	output logic [ACC_BITS-1:0]      sum
);

	localparam int LVLS   = $clog2(NUM_TAPS);
	localparam int LEAVES = 2 ** LVLS;

	logic [ACC_BITS-1:0] leaf [LEAVES];
	logic [ACC_BITS-1:0] node_q [1:LEAVES-1];
	logic [LVLS:0]       vld_q;
	logic [LVLS:0]       rdy;

	// Pad the leaves up to a power of two
	for (genvar j = 0; j < LEAVES; j++) begin : g_leaf
		if (j < NUM_TAPS) begin : g_tap
			assign leaf[j] = prod[j];
		end else begin : g_pad
			assign leaf[j] = '0;
		end
	end

	// A level moves on when it is empty or the next level moves on
	assign rdy[LVLS] = !vld_q[LVLS] || out_ready;
	for (genvar l = 0; l < LVLS; l++) begin : g_rdy
		assign rdy[l] = !vld_q[l] || rdy[l+1];
	end

	// Level 0 marks the product registers in the cells
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q[0] <= 1'b0;
		end else if (rdy[0]) begin
			vld_q[0] <= load;
		end
	end

	for (genvar l = 1; l <= LVLS; l++) begin : g_vld
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[l] <= 1'b0;
			end else if (rdy[l]) begin
				vld_q[l] <= vld_q[l-1];
			end
		end
	end

	// Node i adds its two children; the root is node 1
	for (genvar i = 1; i < LEAVES; i++) begin : g_node
		localparam int STG = LVLS - $clog2(i + 1) + 1;
		logic [ACC_BITS-1:0] lhs;
		logic [ACC_BITS-1:0] rhs;

		if (2 * i >= LEAVES) begin : g_from_leaf
			assign lhs = leaf[2*i - LEAVES];
			assign rhs = leaf[2*i + 1 - LEAVES];
		end else begin : g_from_node
			assign lhs = node_q[2*i];
			assign rhs = node_q[2*i + 1];
		end

		always_ff @(posedge clk) begin
			if (rdy[STG]) begin
				node_q[i] <= lhs + rhs;
			end
		end
	end

	assign ready0    = rdy[0];
	assign out_valid = vld_q[LVLS];
	assign sum       = node_q[1];

endmodule

`default_nettype wire

// ===== design/fir_filter_direct_form.sv =====
// Direct-form FIR filter. A filter beat (opcode 0) shifts its sample into a
// delay line of NUM_TAPS entries and yields one result, the sum of every entry
// times its coefficient wrapped to ACC_BITS bits; a load beat (opcode 1) writes
// one coefficient and yields nothing, and an index at or beyond NUM_TAPS is
// dropped. Delay line and coefficients reset to zero. The block takes one beat
// per clock while it is not stalled. Each tap cell snapshots its product in the
// cycle the sample is taken, and a registered adder tree of $clog2(NUM_TAPS)
// levels sums them; a result passes the product registers and then each tree
// level in turn before it is offered. A load takes effect for the next sample
// beat. The product registers and every tree level each hold one result, so
// input stalls only once all of them are full and the output is held.
`default_nettype none

module fir_filter_direct_form #(
	parameter int NUM_TAPS    = 32,
	parameter int SAMPLE_BITS = 16,
	parameter int COEF_BITS   = 16,
	parameter int ACC_BITS    = 40
) (
	input  wire         clk,
	input  wire         arst_n,
	fir_in_if.sink      din,
	fir_out_if.source   dout
);

	logic                          accept;
	logic                          filt_acc;
	logic                          load_acc;
	logic                          tree_ready;
	logic signed [SAMPLE_BITS-1:0] tap [NUM_TAPS];
	logic [ACC_BITS-1:0]           prod [NUM_TAPS];
	logic [ACC_BITS-1:0]           sum;

	// Decode the accepted beat
	assign accept   = din.valid && tree_ready;
	assign filt_acc = accept && (din.opcode == fir_pkg::OP_FILTER);
	assign load_acc = accept && (din.opcode == fir_pkg::OP_LOAD);

	// Row of tap cells; cell 0 takes the new sample
	for (genvar k = 0; k < NUM_TAPS; k++) begin : g_cell
		fir_pkg::cell_ctl_t            ctl;
		logic signed [SAMPLE_BITS-1:0] d_in;

		assign ctl.shift   = filt_acc;
		assign ctl.coef_we = load_acc && (int'(din.coef_index) == k);

		if (k == 0) begin : g_head
			assign d_in = din.sample;
		end else begin : g_link
			assign d_in = tap[k-1];
		end

		fir_cell #(
			.SAMPLE_BITS (SAMPLE_BITS),
			.COEF_BITS   (COEF_BITS),
			.ACC_BITS    (ACC_BITS)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.d_in    (d_in),
			.coef_in (din.coef_value),
			.d_out   (tap[k]),
			.prod    (prod[k])
		);
	end

	// Sum the snapshot products
	fir_sum_tree #(
		.NUM_TAPS (NUM_TAPS),
		.ACC_BITS (ACC_BITS)
	) u_tree (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (filt_acc),
		.ready0    (tree_ready),
		.prod      (prod),
		.out_valid (dout.valid),
		.out_ready (dout.ready),
		.sum       (sum)
	);

	assign din.ready     = tree_ready;
	assign dout.filtered = sum;

endmodule

`default_nettype wire

// ===== design/fir_chk.sv =====
`default_nettype none

// Port-level checks for the FIR filter
module fir_chk #(
	parameter int NUM_TAPS = 32,
	parameter int ACC_BITS = 40
) (
	input wire                clk,
	input wire                arst_n,
	input wire                in_valid,
	input wire                in_ready,
	input wire                in_opcode,
	input wire                out_valid,
	input wire                out_ready,
	input wire [ACC_BITS-1:0] out_filtered
);

	localparam int DEPTH  = $clog2(NUM_TAPS) + 1;
	localparam int CNT_W  = $clog2(DEPTH + 2);

	logic             filt_beat;
	logic             out_beat;
	logic [CNT_W-1:0] pend_q;

	assign filt_beat = in_valid && in_ready && (in_opcode == fir_pkg::OP_FILTER);
	assign out_beat  = out_valid && out_ready;

	// Track sample beats whose results are not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (filt_beat && !out_beat) begin
			pend_q <= pend_q + 1'b1;
		end else if (out_beat && !filt_beat) begin
			pend_q <= pend_q - 1'b1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_filtered))
		else $error("result dropped or changed while stalled");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != '0)
		else $error("result offered without a pending sample");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= CNT_W'(DEPTH))
		else $error("more samples in flight than pipeline levels");

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with no result waiting");

endmodule

bind fir_filter_direct_form fir_chk #(
	.NUM_TAPS (NUM_TAPS),
	.ACC_BITS (ACC_BITS)
) u_fir_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (din.valid),
	.in_ready     (din.ready),
	.in_opcode    (din.opcode),
	.out_valid    (dout.valid),
	.out_ready    (dout.ready),
	.out_filtered (dout.filtered)
);

`default_nettype wire
